[rtl/core/ookpd_pkg.sv]
// Package for the on-off keyed pulse-distance sensor receiver.
// Holds the channel word types, the sequencer state type, the register map
// and the fixed constants. No dependencies.
package ookpd_pkg;

  typedef struct packed {
    logic [7:0] i_sample;
    logic [7:0] q_sample;
  } in_word_t;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic [7:0]         humidity;
    logic               frame_status;
  } out_word_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQ_I,
    S_SQ_Q,
    S_MAC_FB,
    S_MAC_NOW,
    S_MAC_PREV,
    S_SUM,
    S_DECODE
  } state_t;

  typedef enum logic [2:0] {
    REG_LEVEL_THRESHOLD = 3'd0,
    REG_SHORT_LIMIT     = 3'd1,
    REG_LONG_LIMIT      = 3'd2,
    REG_END_LIMIT       = 3'd3,
    REG_FEEDBACK_COEF   = 3'd4,
    REG_INPUT_COEF_NOW  = 3'd5,
    REG_INPUT_COEF_PREV = 3'd6
  } reg_idx_t;

  localparam int unsigned CFG_ADDR_W = 5;

  localparam logic [14:0] LEVEL_THRESHOLD_RST = 15'd10000;
  localparam logic [11:0] SHORT_LIMIT_RST     = 12'(3500 / 4);
  localparam logic [11:0] LONG_LIMIT_RST      = 12'(7000 / 4);
  localparam logic [11:0] END_LIMIT_RST       = 12'(15000 / 4);
  localparam logic [14:0] FEEDBACK_COEF_RST   = 15'd31754;
  localparam logic [14:0] INPUT_COEF_RST      = 15'd506;

  localparam logic [11:0] GAP_COUNT_MAX   = 12'd4095;
  localparam logic [1:0]  ROW_PAST_ONE    = 2'd2;
  localparam logic [1:0]  ROW_ONE         = 2'd1;
  localparam logic [5:0]  BIT_POS_MAX     = 6'd63;
  localparam logic [5:0]  PAYLOAD_FIRST   = 6'd16;
  localparam logic [5:0]  PAYLOAD_END     = 6'd36;

  localparam int unsigned ACC_W   = 32;
  localparam int unsigned FILT_SH = 14;

endpackage

[rtl/core/ook_pulse_distance_sensor_receiver_top.sv]
// On-off keyed pulse-distance sensor receiver: envelope, low-pass filter,
// pulse-distance decoder and APB-style register block in one module.
// Depends on ookpd_pkg.
//
// Each accepted I/Q word runs through the sequencer steps in order: accepting
// it, the two squares of the envelope, the three filter products, adding the
// last product, and clamping the filtered level and stepping the decoder. All
// five products go through a single 17x17 signed multiplier under a small
// sequencer, and in_stall stays high until the decode step is done. Results
// sit in an output register, so a new sample is taken while a result waits;
// should the decode step produce a second result before the first is taken,
// that step waits for the output register to drain. Configuration registers
// sit at byte addresses 4*index and are to be written only while idle.
module ook_pulse_distance_sensor_receiver_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  ookpd_pkg::in_word_t                 in_data,
  output logic                                out_valid,
  input  logic                                out_stall,
  output ookpd_pkg::out_word_t                out_data,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [ookpd_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [31:0]                         pwdata,
  output logic [31:0]                         prdata,
  output logic                                pready
);
  import ookpd_pkg::*;

  // Configuration registers.
  logic [14:0] level_r;
  logic [11:0] short_r, long_r, end_r;
  logic [14:0] fb_coef_r, now_coef_r, prev_coef_r;

  logic        cfg_wr;
  logic [2:0]  cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = paddr[CFG_ADDR_W-1:2];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r     <= LEVEL_THRESHOLD_RST;
      short_r     <= SHORT_LIMIT_RST;
      long_r      <= LONG_LIMIT_RST;
      end_r       <= END_LIMIT_RST;
      fb_coef_r   <= FEEDBACK_COEF_RST;
      now_coef_r  <= INPUT_COEF_RST;
      prev_coef_r <= INPUT_COEF_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_LEVEL_THRESHOLD: level_r     <= pwdata[14:0];
        REG_SHORT_LIMIT:     short_r     <= pwdata[11:0];
        REG_LONG_LIMIT:      long_r      <= pwdata[11:0];
        REG_END_LIMIT:       end_r       <= pwdata[11:0];
        REG_FEEDBACK_COEF:   fb_coef_r   <= pwdata[14:0];
        REG_INPUT_COEF_NOW:  now_coef_r  <= pwdata[14:0];
        REG_INPUT_COEF_PREV: prev_coef_r <= pwdata[14:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_LEVEL_THRESHOLD: prdata = {17'd0, level_r};
      REG_SHORT_LIMIT:     prdata = {20'd0, short_r};
      REG_LONG_LIMIT:      prdata = {20'd0, long_r};
      REG_END_LIMIT:       prdata = {20'd0, end_r};
      REG_FEEDBACK_COEF:   prdata = {17'd0, fb_coef_r};
      REG_INPUT_COEF_NOW:  prdata = {17'd0, now_coef_r};
      REG_INPUT_COEF_PREV: prdata = {17'd0, prev_coef_r};
      default:             prdata = 32'd0;
    endcase
  end

  // Sequencer.
  state_t state_r, state_nxt;
  logic   in_accept, out_take, decode_go;
  logic   emit;

  assign in_stall  = (state_r != S_IDLE);
  assign in_accept = in_valid & ~in_stall;
  assign out_take  = out_valid & ~out_stall;
  // A decode step that ends a transmission waits until the output register
  // can take its word.
  assign decode_go = ~emit | ~out_valid | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:     if (in_accept) state_nxt = S_SQ_I;
      S_SQ_I:     state_nxt = S_SQ_Q;
      S_SQ_Q:     state_nxt = S_MAC_FB;
      S_MAC_FB:   state_nxt = S_MAC_NOW;
      S_MAC_NOW:  state_nxt = S_MAC_PREV;
      S_MAC_PREV: state_nxt = S_SUM;
      S_SUM:      state_nxt = S_DECODE;
      S_DECODE:   if (decode_go) state_nxt = S_IDLE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  // Shared multiplier and accumulator.
  logic [7:0]              samp_i_r, samp_q_r;
  logic signed [8:0]       diff_i, diff_q;
  logic signed [16:0]      mul_a, mul_b;
  logic signed [33:0]      mul_full;
  logic signed [ACC_W-1:0] prod_r, prod_half;
  logic signed [ACC_W-1:0] acc_r;
  logic [15:0]             env_r;
  logic [15:0]             prev_env_r;
  logic signed [15:0]      prev_filt_r;

  assign diff_i = 9'sd128 - $signed({1'b0, samp_i_r});
  assign diff_q = 9'sd128 - $signed({1'b0, samp_q_r});

  always_comb begin
    mul_a = 17'sd0;
    mul_b = 17'sd0;
    unique case (state_r)
      S_SQ_I: begin
        mul_a = 17'(diff_i);
        mul_b = 17'(diff_i);
      end
      S_SQ_Q: begin
        mul_a = 17'(diff_q);
        mul_b = 17'(diff_q);
      end
      S_MAC_FB: begin
        mul_a = $signed({2'b00, fb_coef_r});
        mul_b = 17'(prev_filt_r);
      end
      S_MAC_NOW: begin
        mul_a = $signed({2'b00, now_coef_r});
        mul_b = $signed({1'b0, env_r});
      end
      S_MAC_PREV: begin
        mul_a = $signed({2'b00, prev_coef_r});
        mul_b = $signed({1'b0, prev_env_r});
      end
      default: ;
    endcase
  end

  // Products stay below 2**30 in magnitude; 32 bits hold them and the sum of halves.
  assign mul_full  = mul_a * mul_b;
  assign prod_half = prod_r >>> 1;

  always_ff @(posedge clk) begin
    if (in_accept) begin
      samp_i_r <= in_data.i_sample;
      samp_q_r <= in_data.q_sample;
    end
    prod_r <= mul_full[ACC_W-1:0];
    unique case (state_r)
      S_SQ_Q:     env_r <= prod_r[15:0];
      S_MAC_FB:   env_r <= env_r + prod_r[15:0];
      S_MAC_NOW:  acc_r <= prod_half;
      S_MAC_PREV: acc_r <= acc_r + prod_half;
      S_SUM:      acc_r <= acc_r + prod_half;
      default: ;
    endcase
  end

  // Clamp of the filtered level.
  logic signed [ACC_W-FILT_SH-1:0] y_wide;
  logic signed [15:0]              filt;

  assign y_wide = acc_r[ACC_W-1:FILT_SH];

  always_comb begin
    if (y_wide[ACC_W-FILT_SH-1:15] == '0 || y_wide[ACC_W-FILT_SH-1:15] == '1) begin
      filt = y_wide[15:0];
    end else if (y_wide[ACC_W-FILT_SH-1]) begin
      filt = 16'sh8000;
    end else begin
      filt = 16'sh7FFF;
    end
  end

  // Pulse-distance decoder.
  logic        in_pulse_r, counting_r, gap_open_r;
  logic [11:0] gap_cnt_r;
  logic [1:0]  row_r;
  logic [5:0]  bit_pos_r;
  logic [19:0] payload_r;

  logic        in_pulse_nxt, counting_nxt, gap_open_nxt;
  logic [11:0] gap_cnt_nxt;
  logic [1:0]  row_nxt;
  logic [5:0]  bit_pos_nxt;
  logic [19:0] payload_nxt;
  out_word_t   word_nxt;

  always_comb begin
    logic pulse, silence, one_bit, complete;
    logic signed [15:0] lvl;
    lvl          = $signed({1'b0, level_r});
    pulse        = filt > lvl;
    silence      = filt < lvl;
    in_pulse_nxt = in_pulse_r;
    counting_nxt = counting_r;
    gap_open_nxt = gap_open_r;
    gap_cnt_nxt  = gap_cnt_r;
    row_nxt      = row_r;
    bit_pos_nxt  = bit_pos_r;
    payload_nxt  = payload_r;
    emit         = 1'b0;
    word_nxt     = '0;
    one_bit      = 1'b0;
    complete     = 1'b0;

    if (pulse) begin
      in_pulse_nxt = 1'b1;
      counting_nxt = 1'b1;
    end
    if (in_pulse_nxt && silence) begin
      gap_open_nxt = 1'b1;
      gap_cnt_nxt  = 12'd0;
      in_pulse_nxt = 1'b0;
    end
    if (counting_nxt && gap_cnt_nxt != GAP_COUNT_MAX) begin
      gap_cnt_nxt = gap_cnt_nxt + 12'd1;
    end
    if (gap_open_nxt && pulse) begin
      if (gap_cnt_nxt < long_r) begin
        one_bit = gap_cnt_nxt > short_r;
        if (row_r == ROW_ONE) begin
          if (bit_pos_r >= PAYLOAD_FIRST && bit_pos_r < PAYLOAD_END) begin
            payload_nxt = {payload_r[18:0], one_bit};
          end
          if (bit_pos_r != BIT_POS_MAX) begin
            bit_pos_nxt = bit_pos_r + 6'd1;
          end
        end
      end else begin
        if (row_r != ROW_PAST_ONE) begin
          row_nxt = row_r + 2'd1;
        end
        in_pulse_nxt = 1'b0;
        gap_cnt_nxt  = 12'd0;
      end
      gap_open_nxt = 1'b0;
    end
    if (gap_cnt_nxt > end_r) begin
      // End of transmission: report row one and start over in row zero.
      complete     = (row_nxt != 2'd0) && (bit_pos_nxt >= PAYLOAD_END);
      emit         = 1'b1;
      counting_nxt = 1'b0;
      gap_cnt_nxt  = 12'd0;
      gap_open_nxt = 1'b0;
      if (complete) begin
        word_nxt.temperature_tenths = $signed(payload_nxt[19:8]);
        word_nxt.humidity           = payload_nxt[7:0];
        word_nxt.frame_status       = 1'b0;
      end else begin
        word_nxt.frame_status = 1'b1;
      end
      row_nxt     = 2'd0;
      bit_pos_nxt = 6'd0;
      payload_nxt = 20'd0;
    end
  end

  logic do_decode;
  assign do_decode = (state_r == S_DECODE) && decode_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_env_r  <= 16'd0;
      prev_filt_r <= 16'sd0;
      in_pulse_r  <= 1'b0;
      counting_r  <= 1'b0;
      gap_open_r  <= 1'b0;
      gap_cnt_r   <= 12'd0;
      row_r       <= 2'd0;
      bit_pos_r   <= 6'd0;
      payload_r   <= 20'd0;
    end else if (do_decode) begin
      prev_env_r  <= env_r;
      prev_filt_r <= filt;
      in_pulse_r  <= in_pulse_nxt;
      counting_r  <= counting_nxt;
      gap_open_r  <= gap_open_nxt;
      gap_cnt_r   <= gap_cnt_nxt;
      row_r       <= row_nxt;
      bit_pos_r   <= bit_pos_nxt;
      payload_r   <= payload_nxt;
    end
  end

  // Output register.
  logic      out_valid_r;
  out_word_t out_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (do_decode && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_take) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (do_decode && emit) begin
      out_word_r <= word_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_word_r;

  // Checks.
  a_result_from_decode: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DECODE)
    else $error("result word appeared outside the decode step");

  a_accept_starts_run: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == S_SQ_I)
    else $error("accepted sample did not start the multiplier sequence");

  a_bits_only_in_rows: assert property (@(posedge clk) disable iff (!rst_n)
    bit_pos_r != 6'd0 |-> row_r != 2'd0)
    else $error("bits counted while still in row zero");

  a_payload_after_first: assert property (@(posedge clk) disable iff (!rst_n)
    payload_r != 20'd0 |-> bit_pos_r > PAYLOAD_FIRST)
    else $error("payload bits present before bit sixteen of row one");

endmodule

[sim/ook_pulse_distance_sensor_receiver_top_tb.sv]
// Self-checking testbench for the on-off keyed pulse-distance sensor receiver.
// Sends I/Q sample words, predicts the decoded readings with its own copy of the
// envelope, filter and decoder, and compares every result word. Uses ookpd_pkg.
module ook_pulse_distance_sensor_receiver_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ookpd_pkg::*;

  localparam int CYCLE_LIMIT   = 1_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam logic FRAME_OK    = 1'b0;
  localparam logic FRAME_SHORT = 1'b1;
  localparam logic [CFG_ADDR_W-1:0] UNUSED_ADDR = {3'(REG_INPUT_COEF_PREV) + 3'd1, 2'b00};

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  out_word_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  ook_pulse_distance_sensor_receiver_top u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  initial forever #4 clk = ~clk;

  // Register shadow.
  logic [14:0] thr_q   = LEVEL_THRESHOLD_RST;
  logic [11:0] short_q = SHORT_LIMIT_RST;
  logic [11:0] long_q  = LONG_LIMIT_RST;
  logic [11:0] end_q   = END_LIMIT_RST;
  logic [14:0] fb_q    = FEEDBACK_COEF_RST;
  logic [14:0] cn_q    = INPUT_COEF_RST;
  logic [14:0] cp_q    = INPUT_COEF_RST;

  // Filter history and decoder state.
  logic [15:0]        env_hist   = '0;
  logic signed [15:0] level_hist = '0;
  logic               pulse_on   = 1'b0;
  logic               counting   = 1'b0;
  logic               gap_armed  = 1'b0;
  logic [11:0]        gap_ctr    = '0;
  logic [1:0]         row_idx    = '0;
  logic [5:0]         bits_seen  = '0;
  logic [19:0]        frame_bits = '0;

  out_word_t readings_due[$];
  int samples_sent = 0;
  int readings_predicted = 0;
  int mismatches = 0;
  int cycle_count = 0;
  bit idle_on = 1'b1;
  int hold_request = 0;
  int hold_left = 0;
  int stall_left = 0;

  task automatic report_mismatch(input string what);
    mismatches++;
    if (mismatches <= 50) $display("[%0t] mismatch: %s", $time, what);
  endtask

  task automatic decode_sample(input in_word_t w);
    int di;
    int dq;
    int env_now;
    int f;
    int lvl;
    longint acc;
    longint y;
    out_word_t rd;
    di = 128 - int'(w.i_sample);
    dq = 128 - int'(w.q_sample);
    env_now = di * di + dq * dq;
    acc = ((longint'(fb_q) * longint'(level_hist)) >>> 1)
        + ((longint'(cn_q) * longint'(env_now)) >>> 1)
        + ((longint'(cp_q) * longint'(env_hist)) >>> 1);
    y = acc >>> FILT_SH;
    if (y > 32767) y = 32767;
    if (y < -32768) y = -32768;
    f = int'(y);
    lvl = int'(thr_q);
    env_hist = 16'(env_now);
    level_hist = 16'(f);

    // A level equal to the threshold neither starts nor ends a pulse.
    if (f > lvl) begin
      pulse_on = 1'b1;
      counting = 1'b1;
    end
    if (pulse_on && f < lvl) begin
      gap_armed = 1'b1;
      gap_ctr = '0;
      pulse_on = 1'b0;
    end
    if (counting && gap_ctr < GAP_COUNT_MAX) gap_ctr++;
    if (gap_armed && f > lvl) begin
      if (gap_ctr < long_q) begin
        if (row_idx == ROW_ONE) begin
          if (bits_seen >= PAYLOAD_FIRST && bits_seen < PAYLOAD_END)
            frame_bits = {frame_bits[18:0], gap_ctr > short_q};
          if (bits_seen < BIT_POS_MAX) bits_seen++;
        end
      end else begin
        if (row_idx < ROW_PAST_ONE) row_idx++;
        pulse_on = 1'b0;
        gap_ctr = '0;
      end
      gap_armed = 1'b0;
    end
    if (gap_ctr > end_q) begin
      if (row_idx >= ROW_ONE && bits_seen >= PAYLOAD_END) begin
        rd.temperature_tenths = frame_bits[19:8];
        rd.humidity = frame_bits[7:0];
        rd.frame_status = FRAME_OK;
      end else begin
        rd = '0;
        rd.frame_status = FRAME_SHORT;
      end
      counting = 1'b0;
      gap_ctr = '0;
      gap_armed = 1'b0;
      row_idx = '0;
      bits_seen = '0;
      frame_bits = '0;
      readings_due = {readings_due, rd};
      readings_predicted++;
    end
  endtask

  // Called just after the clock rises; returns when the block has taken the word.
  task automatic send_sample(input in_word_t w);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    samples_sent++;
    decode_sample(w);
  endtask

  task automatic check_reading(input out_word_t got);
    out_word_t want;
    if (readings_due.size() == 0) begin
      report_mismatch($sformatf("reading %h with none outstanding", got));
      return;
    end
    want = readings_due.pop_front();
    if (got.temperature_tenths !== want.temperature_tenths)
      report_mismatch($sformatf("temperature %0d, expected %0d",
                                got.temperature_tenths, want.temperature_tenths));
    if (got.humidity !== want.humidity)
      report_mismatch($sformatf("humidity %0d, expected %0d", got.humidity, want.humidity));
    if (got.frame_status !== want.frame_status)
      report_mismatch($sformatf("frame status %b, expected %b",
                                got.frame_status, want.frame_status));
  endtask

  // Result side: checks each word taken and drives out_stall.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) check_reading(out_data);
    if (hold_request > 0) begin
      hold_left = hold_request;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
    end
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("ook_pulse_distance_sensor_receiver_top_tb: done, errors");
    $finish;
  end

  task automatic wait_quiet();
    in_valid <= 1'b0;
    while (readings_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write_addr(input logic [CFG_ADDR_W-1:0] addr, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic cfg_write(input reg_idx_t idx, input logic [31:0] value);
    cfg_write_addr({idx, 2'b00}, value);
    case (idx)
      REG_LEVEL_THRESHOLD: thr_q = value[14:0];
      REG_SHORT_LIMIT:     short_q = value[11:0];
      REG_LONG_LIMIT:      long_q = value[11:0];
      REG_END_LIMIT:       end_q = value[11:0];
      REG_FEEDBACK_COEF:   fb_q = value[14:0];
      REG_INPUT_COEF_NOW:  cn_q = value[14:0];
      REG_INPUT_COEF_PREV: cp_q = value[14:0];
      default: ;
    endcase
  endtask

  task automatic check_register(input reg_idx_t idx);
    logic [31:0] want;
    case (idx)
      REG_LEVEL_THRESHOLD: want = 32'(thr_q);
      REG_SHORT_LIMIT:     want = 32'(short_q);
      REG_LONG_LIMIT:      want = 32'(long_q);
      REG_END_LIMIT:       want = 32'(end_q);
      REG_FEEDBACK_COEF:   want = 32'(fb_q);
      REG_INPUT_COEF_NOW:  want = 32'(cn_q);
      default:             want = 32'(cp_q);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want)
      report_mismatch($sformatf("register %s reads %h, expected %h", idx.name(), prdata, want));
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  task automatic check_all_registers();
    for (int k = 0; k <= int'(REG_INPUT_COEF_PREV); k++) check_register(reg_idx_t'(k));
  endtask

  task automatic set_config(input int thr, input int short_lim, input int long_lim,
                            input int end_lim, input int fb, input int cn, input int cp);
    wait_quiet();
    cfg_write(REG_LEVEL_THRESHOLD, thr);
    cfg_write(REG_SHORT_LIMIT, short_lim);
    cfg_write(REG_LONG_LIMIT, long_lim);
    cfg_write(REG_END_LIMIT, end_lim);
    cfg_write(REG_FEEDBACK_COEF, fb);
    cfg_write(REG_INPUT_COEF_NOW, cn);
    cfg_write(REG_INPUT_COEF_PREV, cp);
  endtask

  function automatic in_word_t iq(input int i_val, input int q_val);
    in_word_t w;
    w.i_sample = 8'(i_val);
    w.q_sample = 8'(q_val);
    return w;
  endfunction

  function automatic logic [7:0] strong_component();
    return $urandom_range(0, 1) ? 8'($urandom_range(0, 20)) : 8'($urandom_range(236, 255));
  endfunction

  function automatic in_word_t loud_sample();
    in_word_t w;
    w.i_sample = strong_component();
    w.q_sample = strong_component();
    return w;
  endfunction

  function automatic in_word_t quiet_sample();
    return iq($urandom_range(118, 138), $urandom_range(118, 138));
  endfunction

  task automatic send_pulse();
    repeat ($urandom_range(2, 3)) send_sample(loud_sample());
  endtask

  task automatic send_silence(input int n);
    repeat (n) send_sample(quiet_sample());
  endtask

  // One bit: a gap whose length encodes the value, closed by a pulse.
  task automatic send_bit();
    if ($urandom_range(0, 1)) send_silence($urandom_range(int'(short_q), int'(long_q) - 2));
    else send_silence($urandom_range(1, int'(short_q) - 1));
    send_pulse();
  endtask

  task automatic send_row_break();
    send_silence($urandom_range(int'(long_q) - 1, int'(end_q)));
    send_pulse();
  endtask

  // row_one_bits below zero: no row break at all.
  task automatic send_frame(input int lead_bits, input int row_one_bits, input int extra_rows);
    send_pulse();
    repeat (lead_bits) send_bit();
    if (row_one_bits >= 0) begin
      send_row_break();
      repeat (row_one_bits) send_bit();
      repeat (extra_rows) begin
        send_row_break();
        repeat ($urandom_range(0, 5)) send_bit();
      end
    end
    send_silence($urandom_range(int'(end_q) + 1, int'(end_q) + 3));
  endtask

  task automatic test_default_config();
    check_all_registers();
    repeat (60) send_sample(in_word_t'(16'($urandom())));
  endtask

  task automatic test_register_map();
    wait_quiet();
    for (int k = 0; k <= int'(REG_INPUT_COEF_PREV); k++) begin
      cfg_write(reg_idx_t'(k), 32'd0);
      check_register(reg_idx_t'(k));
      cfg_write(reg_idx_t'(k), 32'hFFFF_FFFF);
      check_register(reg_idx_t'(k));
      cfg_write(reg_idx_t'(k), $urandom());
    end
    // A write past the last register must leave every register alone.
    cfg_write_addr(UNUSED_ADDR, 32'hFFFF_FFFF);
    check_all_registers();
  endtask

  // Extreme sample values through a near unity filter; the level of a
  // half-scale envelope is made to sit exactly on the threshold.
  task automatic test_edge_samples();
    set_config(16383, 2, 4, 6, 0, 32767, 0);
    send_sample(iq(128, 128));
    send_sample(iq(0, 0));
    send_sample(iq(255, 255));
    send_sample(iq(0, 128));
    send_sample(iq(128, 0));
    send_sample(iq(255, 0));
    send_sample(iq(0, 255));
    send_sample(iq(127, 129));
    repeat (8) send_sample(iq(128, 128));
  endtask

  task automatic test_filter_clamp();
    set_config(32767, 4095, 4095, 4095, 32767, 32767, 32767);
    repeat (20) send_sample(iq(0, 0));
    repeat (6) send_sample(in_word_t'(16'($urandom())));
  endtask

  // With every limit at zero each pulse sample ends a transmission, so a long
  // hold-off on the result side fills the block and stalls its input.
  task automatic test_output_backpressure();
    set_config(0, 0, 0, 0, 0, 32767, 0);
    hold_request = 300;
    repeat (40) send_sample($urandom_range(0, 3) != 0 ? loud_sample() : iq(128, 128));
  endtask

  // A gap far past the long limit with the end limit at its top value, then a
  // lower end limit closes the transmission.
  task automatic test_long_gap();
    set_config(16000, 2, 4, 4095, 0, 32767, 0);
    send_pulse();
    send_silence(150);
    send_pulse();
    send_silence(10);
    wait_quiet();
    cfg_write(REG_END_LIMIT, 6);
    send_silence(8);
  endtask

  task automatic test_random_frames(input int min_samples, input int min_readings);
    int first_sample;
    int first_reading;
    int pick;
    set_config($urandom_range(5000, 15000), 0, 0, 0, $urandom_range(0, 2000),
               $urandom_range(28000, 32767), $urandom_range(0, 2000));
    cfg_write(REG_SHORT_LIMIT, $urandom_range(2, 4));
    cfg_write(REG_LONG_LIMIT, int'(short_q) + $urandom_range(2, 3));
    cfg_write(REG_END_LIMIT, int'(long_q) + $urandom_range(1, 3));
    first_sample = samples_sent;
    first_reading = readings_predicted;
    while ((samples_sent - first_sample < min_samples ||
            readings_predicted - first_reading < min_readings) &&
           samples_sent - first_sample < 20000) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)
        send_frame($urandom_range(0, 3),
                   $urandom_range(0, 4) == 0 ? $urandom_range(37, 70) : 36, 0);
      else if (pick < 70)
        send_frame($urandom_range(0, 3), $urandom_range(0, 35), 0);
      else if (pick < 80)
        send_frame($urandom_range(0, 8), -1, 0);
      else if (pick < 90)
        send_frame($urandom_range(0, 3), 36, $urandom_range(1, 2));
      else
        repeat ($urandom_range(5, 30)) send_sample(in_word_t'(16'($urandom())));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_default_config();
    test_register_map();
    test_edge_samples();
    test_filter_clamp();
    test_output_backpressure();
    test_long_gap();
    test_random_frames(200, 2);
    test_random_frames(150, 1);
    idle_on = 1'b0;
    test_random_frames(100, 1);
    wait_quiet();
    if (mismatches == 0) begin
      $display("ook_pulse_distance_sensor_receiver_top_tb: done, clean");
    end else begin
      $display("ook_pulse_distance_sensor_receiver_top_tb: done, errors");
    end
    $finish;
  end

endmodule

[ook_pulse_distance_sensor_receiver_top.f]
rtl/core/ookpd_pkg.sv
rtl/core/ook_pulse_distance_sensor_receiver_top.sv
sim/ook_pulse_distance_sensor_receiver_top_tb.sv
